// ----- hdl/strt_pkg.sv -----
// Package with shared types and constants for the sample time run table.
`timescale 1ns / 1ps
package strt_pkg;
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_S2T    = 2'd1;
  localparam logic [1:0] CMD_T2S    = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [31:0] LONE_DURATION = 32'd1024;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] time_value;
    logic [31:0] sample_number;
    logic        final_timestamp;
  } req_t;

  typedef struct packed {
    logic [63:0] time_result;
    logic [31:0] sample_result;
    logic [1:0]  status;
  } rsp_t;

  // Operations issued by the controller to the datapath.
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_APPEND_RD, OP_APPEND_WR, OP_CLEAR, OP_SRCH_RD,
    OP_SRCH_UPD, OP_ENTRY_RD, OP_CALC, OP_MUL, OP_DIV_STEP, OP_FINISH
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic srch_done;
    logic div_done;
    logic is_empty;
    logic [1:0] command;
  } stat_t;
endpackage

// ----- hdl/strt_if.sv -----
// Valid/ready channel interface carrying one transaction payload.
`timescale 1ns / 1ps
interface strt_if #(parameter int W = 8) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/sample_time_run_table.sv -----
// Top level of the sample time run table.
`timescale 1ns / 1ps
// Builds a run-length time-to-sample table from appended timestamps and answers
// sample-to-time and time-to-sample lookups; one transaction in, one result out.
// An append passes from the accepting cycle through the dispatch and append-write
// states, a clear or a lookup on an empty table ends in dispatch; the result is
// valid in the cycle after. A lookup runs a binary search over the run table, a
// read state and an update state per halving through its single read port;
// time to sample adds a restoring divider that retires one quotient bit a cycle.
// A new transaction is taken only once the previous result has left or leaves in
// the same cycle.
module sample_time_run_table #(
  parameter int MAX_RUNS = 256
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  strt_if.sink   in_i,
  strt_if.source out_o
);
  import strt_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  rsp_t  rsp;

  strt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  strt_dp #(.MAX_RUNS(MAX_RUNS)) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_t'(in_i.data)),
    .cmd_i  (cmd),
    .stat_o (stat),
    .rsp_o  (rsp)
  );

  assign out_o.data = rsp;
endmodule

// ----- hdl/strt_ctrl.sv -----
// Controller state machine sequencing appends, clears and table lookups.
`timescale 1ns / 1ps
module strt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  strt_pkg::stat_t stat_i,
  output strt_pkg::cmd_t  cmd_o
);
  import strt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_APPWR = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_SUPD = 3'd4;
  localparam logic [2:0] S_ENTRY = 3'd5;
  localparam logic [2:0] S_CALC = 3'd6;
  localparam logic [2:0] S_DIV = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       mul_q, mul_d;
  logic       fin;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  // Next state and the command for the datapath.
  always_comb begin
    state_d = state_q;
    mul_d = mul_q;
    cmd_o.op = OP_NONE;
    fin = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.op = OP_LOAD;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat_i.command == CMD_APPEND) begin
          cmd_o.op = OP_APPEND_RD;
          state_d = S_APPWR;
        end else if (stat_i.command == CMD_CLEAR) begin
          cmd_o.op = OP_CLEAR;
          fin = 1'b1;
        end else if (stat_i.is_empty) begin
          fin = 1'b1;
        end else begin
          state_d = S_SRCH;
        end
      end
      S_APPWR: begin
        cmd_o.op = OP_APPEND_WR;
        fin = 1'b1;
      end
      S_SRCH: begin
        if (stat_i.srch_done) begin
          cmd_o.op = OP_ENTRY_RD;
          state_d = S_ENTRY;
        end else begin
          cmd_o.op = OP_SRCH_RD;
          state_d = S_SUPD;
        end
      end
      S_SUPD: begin
        cmd_o.op = OP_SRCH_UPD;
        state_d = S_SRCH;
      end
      S_ENTRY: begin
        cmd_o.op = OP_CALC;
        state_d = S_CALC;
        mul_d = 1'b0;
      end
      S_CALC: begin
        if (stat_i.command == CMD_S2T) begin
          if (!mul_q) begin
            cmd_o.op = OP_MUL;
            mul_d = 1'b1;
          end else begin
            cmd_o.op = OP_FINISH;
            fin = 1'b1;
          end
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.op = OP_FINISH;
          fin = 1'b1;
        end else begin
          cmd_o.op = OP_DIV_STEP;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (fin) state_d = S_IDLE;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (fin) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
      mul_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      mul_q <= mul_d;
    end
  end
endmodule

// ----- hdl/strt_dp.sv -----
// Datapath with the run table memory, search registers and serial divider.
`timescale 1ns / 1ps
module strt_dp #(
  parameter int MAX_RUNS = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  strt_pkg::req_t   req_i,
  input  strt_pkg::cmd_t   cmd_i,
  output strt_pkg::stat_t  stat_o,
  output strt_pkg::rsp_t   rsp_o
);
  import strt_pkg::*;

  localparam int AW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int CW = $clog2(MAX_RUNS + 1);
  localparam int EW = 32 + 64 + 32 + 32;

  // Run table: first sample, start time, step, length.
  logic [EW-1:0] mem [MAX_RUNS];
  logic [EW-1:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  logic [CW-1:0] runs_q;
  logic [63:0]   prior_q, tsum_q;
  logic [31:0]   nsamp_q;
  logic          closed_q;
  req_t          req_q;
  rsp_t          rsp_q;
  logic [AW-1:0] lo_q, hi_q, mid_q;

  // Working registers of the lookup.
  logic [31:0] e_first, e_step, e_len;
  logic [63:0] e_start;
  logic [31:0] n_q;
  logic [63:0] base_q, rem_q, prod_q;
  logic [31:0] stepv_q, firstv_q, lenv_q;
  logic [63:0] quo_q;
  logic [6:0]  dcnt_q;
  logic        ovf_q;

  assign {e_first, e_start, e_step, e_len} = rd_q;

  assign stat_o.srch_done = (lo_q == hi_q);
  assign stat_o.div_done  = (dcnt_q == 7'd0);
  assign stat_o.is_empty  = (runs_q == '0);
  assign stat_o.command   = req_q.command;
  assign rsp_o = rsp_q;

  logic [AW-1:0] last_idx;
  logic [AW:0]   mid_sum;
  assign last_idx = AW'(runs_q - CW'(1));
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q} + (AW+1)'(1);

  always_comb begin
    rd_addr = last_idx;
    if (cmd_i.op == OP_SRCH_RD) rd_addr = mid_sum[AW:1];
    else if (cmd_i.op == OP_ENTRY_RD) rd_addr = lo_q;
  end

  // Append write decision, using the last run read in the previous cycle.
  logic [31:0] dur;
  logic        extend, app_full, new_run;
  logic [63:0] sum1, sum2;
  logic        c1, c2;
  assign dur = 32'(req_q.time_value - prior_q);
  assign extend = (runs_q != '0) && (e_step == dur);
  assign new_run = !extend;
  assign app_full = new_run && (runs_q >= CW'(MAX_RUNS));
  assign {c1, sum1} = {1'b0, tsum_q} + {33'd0, dur};
  assign {c2, sum2} = {1'b0, (c1 ? '1 : sum1)} + {33'd0, dur};

  // Status of a newly accepted lookup and of an append.
  logic [1:0] load_st, app_st;
  assign load_st = ((runs_q == '0) && (req_i.command inside {CMD_S2T, CMD_T2S}))
                   ? ST_EMPTY : ST_OK;
  assign app_st = (!closed_q && (nsamp_q == '1 || (nsamp_q != '0 && app_full)))
                  ? ST_FULL : ST_OK;

  always_comb begin
    wr_en = 1'b0;
    wr_addr = last_idx;
    wr_data = rd_q;
    if (cmd_i.op == OP_APPEND_WR && !closed_q && nsamp_q != '1) begin
      if (nsamp_q == '0) begin
        wr_en = req_q.final_timestamp;
        wr_addr = '0;
        wr_data = {32'd0, 64'd0, LONE_DURATION, 32'd1};
      end else if (!app_full) begin
        wr_en = 1'b1;
        if (new_run) begin
          wr_addr = AW'(runs_q);
          wr_data = {nsamp_q - 32'd1, tsum_q, dur,
                     req_q.final_timestamp ? 32'd2 : 32'd1};
        end else begin
          wr_data = {e_first, e_start, e_step,
                     e_len + (req_q.final_timestamp ? 32'd2 : 32'd1)};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  // Divider step: restoring, one quotient bit a cycle.
  logic [64:0] trial;
  assign trial = {rem_q[63:0], quo_q[63]} - {33'd0, stepv_q};

  // Multiply result for sample to time: 32x32 product plus saturating add.
  logic [64:0] s2t_sum;
  assign s2t_sum = {1'b0, base_q} + {1'b0, prod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      runs_q <= '0;
      prior_q <= '0;
      tsum_q <= '0;
      nsamp_q <= '0;
      closed_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_CLEAR) begin
        runs_q <= '0;
        prior_q <= '0;
        tsum_q <= '0;
        nsamp_q <= '0;
        closed_q <= 1'b0;
      end else if (cmd_i.op == OP_APPEND_WR && !closed_q && nsamp_q != '1) begin
        if (nsamp_q == '0) begin
          prior_q <= req_q.time_value;
          nsamp_q <= 32'd1;
          if (req_q.final_timestamp) begin
            runs_q <= CW'(1);
            tsum_q <= 64'(LONE_DURATION);
            closed_q <= 1'b1;
          end
        end else if (!app_full) begin
          if (new_run) runs_q <= runs_q + CW'(1);
          if (req_q.final_timestamp) begin
            tsum_q <= c2 ? '1 : sum2;
            closed_q <= 1'b1;
          end else begin
            tsum_q <= c1 ? '1 : sum1;
          end
          prior_q <= req_q.time_value;
          nsamp_q <= nsamp_q + 32'd1;
        end
      end
    end
  end

  // Request capture, search bounds, lookup arithmetic and response.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        req_q <= req_i;
        rsp_q <= {64'd0, 32'd0, load_st};
      end
      OP_APPEND_RD: begin
        lo_q <= '0;
      end
      OP_APPEND_WR: begin
        rsp_q <= {64'd0, 32'd0, app_st};
      end
      OP_CLEAR: rsp_q <= '0;
      OP_SRCH_RD: mid_q <= mid_sum[AW:1];
      OP_SRCH_UPD: begin
        if ((req_q.command == CMD_S2T) ? ({32'd0, e_first} <= {32'd0, req_q.sample_number})
                                       : (e_start <= req_q.time_value))
          lo_q <= mid_q;
        else
          hi_q <= mid_q - AW'(1);
      end
      OP_CALC: begin
        n_q <= req_q.sample_number - e_first;
        base_q <= e_start;
        stepv_q <= e_step;
        firstv_q <= e_first;
        lenv_q <= e_len;
        rem_q <= '0;
        quo_q <= req_q.time_value - e_start;
        dcnt_q <= 7'd64;
      end
      OP_MUL: prod_q <= {32'd0, n_q} * {32'd0, stepv_q};
      OP_DIV_STEP: begin
        if (stepv_q == '0) begin
          dcnt_q <= '0;
          quo_q <= (quo_q == '0) ? 64'd0 : {32'd0, lenv_q};
        end else begin
          dcnt_q <= dcnt_q - 7'd1;
          if (!trial[64]) begin
            rem_q <= trial[63:0];
            quo_q <= {quo_q[62:0], 1'b1};
          end else begin
            rem_q <= {rem_q[62:0], quo_q[63]};
            quo_q <= {quo_q[62:0], 1'b0};
          end
        end
      end
      OP_FINISH: begin
        if (req_q.command == CMD_S2T) begin
          rsp_q.time_result <= s2t_sum[64] ? '1 : s2t_sum[63:0];
        end else begin
          if (quo_q < {32'd0, lenv_q})
            rsp_q.sample_result <= firstv_q + quo_q[31:0];
          else
            rsp_q.sample_result <= firstv_q + lenv_q - 32'd1;
        end
      end
      default: ;
    endcase
    if (cmd_i.op == OP_LOAD) begin
      lo_q <= '0;
      hi_q <= last_idx;
    end
  end
endmodule
